FILE: rtl/modexp_pkg.sv
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Shared types and register codes for the modular exponentiation block.
// ----------------------------------------------------------------------------
package modexp_pkg;

	// configuration register index
	typedef logic [1:0] cfg_index_t;

	localparam cfg_index_t REG_EXPONENT = 2'd0;
	localparam cfg_index_t REG_MODULUS  = 2'd1;

	// square-and-multiply sequencer
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_STEP,
		ST_MUL_ACC,
		ST_MUL_SQ,
		ST_FINISH
	} modexp_state_t;

endpackage

FILE: rtl/modexp_in_if.sv
// ----------------------------------------------------------------------------
// Modular exponentiation input channel
// Valid/ready channel carrying one base value per transaction.
// ----------------------------------------------------------------------------
interface modexp_in_if #(
	parameter int WIDTH = 32
);
	logic             valid;
	logic             ready;
	logic [WIDTH-1:0] base_value;

	modport source (output valid, output base_value, input ready);
	modport sink   (input valid, input base_value, output ready);
endinterface

FILE: rtl/modexp_out_if.sv
// ----------------------------------------------------------------------------
// Modular exponentiation output channel
// Valid/ready channel carrying one result and its error flag per transaction.
// ----------------------------------------------------------------------------
interface modexp_out_if #(
	parameter int WIDTH = 32
);
	logic             valid;
	logic             ready;
	logic [WIDTH-1:0] power_result;
	logic             bad_modulus;

	modport source (output valid, output power_result, output bad_modulus, input ready);
	modport sink   (input valid, input power_result, input bad_modulus, output ready);
endinterface

FILE: rtl/modexp_reduce.sv
// ----------------------------------------------------------------------------
// Serial modular reduction
// Reduces a word modulo m, one dividend bit per cycle, most significant first.
// ----------------------------------------------------------------------------
module modexp_reduce #(
	parameter int WORD_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [WORD_WIDTH-1:0] value,
	input  logic [WORD_WIDTH-1:0] modulus,
	output logic                  done,
	output logic [WORD_WIDTH-1:0] remainder
);
	localparam int CNT_W = $clog2(WORD_WIDTH);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [WORD_WIDTH-1:0] rem_q;
	logic [WORD_WIDTH-1:0] shift_q;
	logic [WORD_WIDTH:0]   trial;
	logic [WORD_WIDTH:0]   trial_sub;
	logic [WORD_WIDTH-1:0] rem_d;

	// remainder stays below m, so 2r + bit is below 2m: one subtract at most
	always_comb begin
		trial     = {rem_q, shift_q[WORD_WIDTH-1]};
		trial_sub = trial - {1'b0, modulus};
		if (trial >= {1'b0, modulus}) begin
			rem_d = trial_sub[WORD_WIDTH-1:0];
		end else begin
			rem_d = trial[WORD_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(WORD_WIDTH - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			rem_q   <= '0;
			shift_q <= value;
		end else if (busy_q) begin
			rem_q   <= rem_d;
			shift_q <= shift_q << 1;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

FILE: rtl/modexp_mulmod.sv
// ----------------------------------------------------------------------------
// Serial modular multiplier
// Forms x * y mod m by shift and add, one multiplier bit per cycle, LSB first.
// ----------------------------------------------------------------------------
module modexp_mulmod #(
	parameter int WORD_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [WORD_WIDTH-1:0] x,
	input  logic [WORD_WIDTH-1:0] y,
	input  logic [WORD_WIDTH-1:0] modulus,
	output logic                  done,
	output logic [WORD_WIDTH-1:0] product
);
	localparam int CNT_W = $clog2(WORD_WIDTH);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [WORD_WIDTH-1:0] acc_q;
	logic [WORD_WIDTH-1:0] dbl_q;
	logic [WORD_WIDTH-1:0] mult_q;
	logic [WORD_WIDTH-1:0] acc_d;
	logic [WORD_WIDTH-1:0] dbl_d;

	// (a + b) mod m for a, b below m
	function automatic logic [WORD_WIDTH-1:0] add_mod(
		input logic [WORD_WIDTH-1:0] a,
		input logic [WORD_WIDTH-1:0] b,
		input logic [WORD_WIDTH-1:0] m
	);
		logic [WORD_WIDTH:0] sum;
		logic [WORD_WIDTH:0] sum_sub;
		sum     = {1'b0, a} + {1'b0, b};
		sum_sub = sum - {1'b0, m};
		if (sum >= {1'b0, m}) begin
			return sum_sub[WORD_WIDTH-1:0];
		end
		return sum[WORD_WIDTH-1:0];
	endfunction

	always_comb begin
		dbl_d = add_mod(dbl_q, dbl_q, modulus);
		if (mult_q[0]) begin
			acc_d = add_mod(acc_q, dbl_q, modulus);
		end else begin
			acc_d = acc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(WORD_WIDTH - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			acc_q  <= '0;
			dbl_q  <= x;
			mult_q <= y;
		end else if (busy_q) begin
			acc_q  <= acc_d;
			dbl_q  <= dbl_d;
			mult_q <= mult_q >> 1;
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

FILE: rtl/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// Modular exponentiation
// Raises each base to the configured exponent modulo the configured modulus.
// ----------------------------------------------------------------------------
// Usage:
//   din carries one base value per transaction; dout returns power_result and
//   bad_modulus for it, in order. exponent and modulus are set through the
//   write port (cfg_we, cfg_index, cfg_data); the user must write them only
//   while the block is idle, as the block itself does not enforce it.
//   One base is worked on at a time. It is first reduced mod m by a serial
//   divider. Each exponent bit up to the highest set one then takes a
//   decision step in ST_STEP, for a set bit a multiply into the accumulator,
//   and a squaring; the multiply and the squaring both go through the single
//   serial modular multiplier. A zero modulus skips the arithmetic and
//   answers through ST_FINISH with bad_modulus set and a zero result.
//   The next base can be taken in the cycle after the result is loaded.
//   The result sits in an output register; din is taken again as soon as the
//   sequencer is idle, even while dout is stalled, and a finished result
//   waits for that register to free up.
//   Reset empties the block and sets exponent and modulus to one.
// ----------------------------------------------------------------------------
module modular_exponentiation #(
	parameter int WORD_WIDTH = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  modexp_pkg::cfg_index_t  cfg_index,
	input  logic [WORD_WIDTH-1:0]   cfg_data,
	modexp_in_if.sink               din,
	modexp_out_if.source            dout
);
	import modexp_pkg::*;

	modexp_state_t state_q;
	modexp_state_t state_d;

	logic [WORD_WIDTH-1:0] exp_q;
	logic [WORD_WIDTH-1:0] mod_q;
	logic [WORD_WIDTH-1:0] e_q;
	logic [WORD_WIDTH-1:0] sq_q;
	logic [WORD_WIDTH-1:0] acc_q;
	logic [WORD_WIDTH-1:0] res_q;
	logic                  bad_q;
	logic                  out_valid_q;

	logic                  m_zero;
	logic                  m_one;
	logic                  in_accept;
	logic                  in_ready;
	logic                  red_start;
	logic                  red_done;
	logic [WORD_WIDTH-1:0] red_result;
	logic                  mul_start;
	logic                  mul_sel_acc;
	logic                  mul_done;
	logic [WORD_WIDTH-1:0] mul_x;
	logic [WORD_WIDTH-1:0] mul_prod;
	logic                  out_load;

	assign m_zero    = (mod_q == '0);
	assign m_one     = (mod_q == WORD_WIDTH'(1));
	assign in_accept = din.valid && in_ready;
	assign mul_x     = mul_sel_acc ? acc_q : sq_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q <= WORD_WIDTH'(1);
			mod_q <= WORD_WIDTH'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_EXPONENT: exp_q <= cfg_data;
				REG_MODULUS:  mod_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					state_d = m_zero ? ST_FINISH : ST_REDUCE;
				end
			end
			ST_REDUCE: begin
				if (red_done) begin
					state_d = ST_STEP;
				end
			end
			ST_STEP: begin
				if (e_q == '0) begin
					state_d = ST_FINISH;
				end else if (e_q[0]) begin
					state_d = ST_MUL_ACC;
				end else begin
					state_d = ST_MUL_SQ;
				end
			end
			ST_MUL_ACC: begin
				if (mul_done) begin
					state_d = ST_MUL_SQ;
				end
			end
			ST_MUL_SQ: begin
				if (mul_done) begin
					state_d = ST_STEP;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || dout.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready    = 1'b0;
		red_start   = 1'b0;
		mul_start   = 1'b0;
		mul_sel_acc = 1'b0;
		out_load    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				red_start = din.valid && !m_zero;
			end
			ST_STEP: begin
				mul_start   = (e_q != '0);
				mul_sel_acc = e_q[0];
			end
			ST_MUL_ACC: begin
				// chain straight into the squaring
				mul_start = mul_done;
			end
			ST_FINISH: begin
				out_load = !out_valid_q || dout.ready;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (dout.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (in_accept) begin
			e_q <= exp_q;
		end
		if (state_q == ST_REDUCE && red_done) begin
			sq_q  <= red_result;
			acc_q <= m_one ? '0 : WORD_WIDTH'(1);
		end
		if (state_q == ST_MUL_ACC && mul_done) begin
			acc_q <= mul_prod;
		end
		if (state_q == ST_MUL_SQ && mul_done) begin
			sq_q <= mul_prod;
			e_q  <= e_q >> 1;
		end
		if (out_load) begin
			res_q <= m_zero ? '0 : acc_q;
			bad_q <= m_zero;
		end
	end

	modexp_reduce #(
		.WORD_WIDTH (WORD_WIDTH)
	) u_reduce (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (red_start),
		.value     (din.base_value),
		.modulus   (mod_q),
		.done      (red_done),
		.remainder (red_result)
	);

	modexp_mulmod #(
		.WORD_WIDTH (WORD_WIDTH)
	) u_mulmod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.x       (mul_x),
		.y       (sq_q),
		.modulus (mod_q),
		.done    (mul_done),
		.product (mul_prod)
	);

	assign din.ready         = in_ready;
	assign dout.valid        = out_valid_q;
	assign dout.power_result = res_q;
	assign dout.bad_modulus  = bad_q;

endmodule

FILE: rtl/modexp_checker.sv
// ----------------------------------------------------------------------------
// Modular exponentiation checker
// Port-level assertions on the channels, bound to the top level.
// ----------------------------------------------------------------------------
module modexp_checker #(
	parameter int WORD_WIDTH = 32
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [WORD_WIDTH-1:0] power_result,
	input logic                  bad_modulus
);

	// a stalled result must not be withdrawn
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(power_result) && $stable(bad_modulus))
		else $error("result changed while stalled");

	// one base at a time: input closes after each transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a base is in progress");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_modulus |-> power_result == '0)
		else $error("non-zero result with bad modulus");

endmodule

bind modular_exponentiation modexp_checker #(
	.WORD_WIDTH (WORD_WIDTH)
) u_modexp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (din.valid),
	.in_ready     (din.ready),
	.out_valid    (dout.valid),
	.out_ready    (dout.ready),
	.power_result (dout.power_result),
	.bad_modulus  (dout.bad_modulus)
);
